/* rtl/pidc_pkg.sv */
// Package for the clamped PID controller core: sequencer state types,
// register indexes and fixed-point constants.
// No dependencies.
`default_nettype none

package pidc_pkg;

    // Sequencer states of the controller.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_NEXT,
        ST_INT,
        ST_ADDP,
        ST_ADDD,
        ST_DONE
    } state_t;

    // Which product or quotient the shared serial units are working on.
    typedef enum logic [2:0] {
        PH_P,
        PH_D,
        PH_K,
        PH_DD,
        PH_I,
        PH_T,
        PH_DI
    } phase_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_GAIN_P        = 3'd0;
    localparam logic [2:0] REG_GAIN_I        = 3'd1;
    localparam logic [2:0] REG_GAIN_D        = 3'd2;
    localparam logic [2:0] REG_OUT_LOW       = 3'd3;
    localparam logic [2:0] REG_OUT_HIGH      = 3'd4;
    localparam logic [2:0] REG_CLAMP_ENABLE  = 3'd5;
    localparam logic [2:0] REG_INTEGRAL_LOW  = 3'd6;
    localparam logic [2:0] REG_INTEGRAL_HIGH = 3'd7;

    localparam int          FRAC_BITS     = 16;
    localparam logic [15:0] MS_PER_SECOND = 16'd1000;
    // Added to a magnitude before the fraction shift so that negative
    // values round toward minus infinity.
    localparam logic [64:0] FLOOR_ROUND   = (65'd1 << FRAC_BITS) - 65'd1;

    // Serial unit step counts, loaded as count minus one.
    localparam logic [5:0] CNT_MUL32 = 6'd31;
    localparam logic [5:0] CNT_MUL33 = 6'd32;
    localparam logic [5:0] CNT_MUL10 = 6'd9;
    localparam logic [5:0] CNT_MUL16 = 6'd15;
    localparam logic [5:0] CNT_DIV64 = 6'd63;

endpackage

`default_nettype wire

/* rtl/pid_controller_clamped_core.sv */
// Clamped PID controller core: a bit-serial multiplier shared by every term and
// a restoring bit-serial divider shared by the derivative and integral terms, driven by one sequencer.
// Depends on pidc_pkg.
//
// A compute beat runs its multiplies and divides in turn, one bit per cycle,
// and the derivative term is skipped when the elapsed time is zero. Only one
// beat is in flight at a time: the next beat is accepted only after the
// result is loaded into the result register, which waits while a result is held.
// A clear beat zeroes the integral without leaving idle.
// Reset: asynchronous, active low; clears all gains, limits, the previous
// error and the integral to zero, and empties the result register.
`default_nettype none

module pid_controller_clamped_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // [31:0] error_in, [47:32] elapsed_ms
    input  wire logic        s_axis_tuser,   // [0] operation: 0 compute, 1 clear integral
    // Output stream
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,   // [31:0] control_out
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import pidc_pkg::*;

    // Configuration registers.
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [31:0] out_low_reg, out_high_reg;
    logic signed [31:0] int_low_reg, int_high_reg;
    logic               clamp_en_reg;

    // Controller state kept between beats.
    logic signed [31:0] prev_reg;
    logic signed [31:0] integ_reg;

    // Sequencer.
    state_t state_reg, state_next;
    phase_t phase_reg;
    logic [5:0] cnt_reg;

    // Current beat.
    logic signed [31:0] e_reg;
    logic [15:0]        dt_reg;

    // Shared serial datapath. The accumulator doubles as the dividend and
    // quotient shift register of the divider.
    logic [63:0] acc_reg;
    logic [63:0] a_reg;
    logic [32:0] b_reg;
    logic [15:0] rem_reg;
    logic [15:0] dvs_reg;
    logic        sgn_reg;

    // Terms in sign-magnitude form.
    logic [47:0] p_mag_reg;
    logic        p_sgn_reg;
    logic [57:0] d_mag_reg;
    logic        d_sgn_reg;
    logic [52:0] di_mag_reg;
    logic        di_sgn_reg;
    logic signed [61:0] u_reg;

    // Result register.
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic s_fire, out_free, out_load;

    // Datapath helpers.
    logic [63:0]        mul_add;
    logic [16:0]        div_sh;
    logic               div_ge;
    logic [16:0]        div_sub;
    logic [64:0]        rnd_sum;
    logic [48:0]        mag_q;
    logic signed [31:0] in_e;
    logic [31:0]        in_e_abs, gp_abs, gi_abs, gd_abs, e_abs;
    logic signed [32:0] diff;
    logic [32:0]        diff_abs;
    logic signed [54:0] di_signed;
    logic signed [54:0] i_sum;
    logic signed [31:0] i_sat, i_new;
    logic signed [61:0] p_signed, d_signed;
    logic signed [31:0] u_clamped;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign in_e     = s_axis_tdata[31:0];

    assign in_e_abs = in_e[31] ? 32'(-in_e) : 32'(in_e);
    assign e_abs    = e_reg[31] ? 32'(-e_reg) : 32'(e_reg);
    assign gp_abs   = gain_p_reg[31] ? 32'(-gain_p_reg) : 32'(gain_p_reg);
    assign gi_abs   = gain_i_reg[31] ? 32'(-gain_i_reg) : 32'(gain_i_reg);
    assign gd_abs   = gain_d_reg[31] ? 32'(-gain_d_reg) : 32'(gain_d_reg);
    assign diff     = 33'(e_reg) - 33'(prev_reg);
    assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);

    assign mul_add  = b_reg[0] ? acc_reg + a_reg : acc_reg;
    assign div_sh   = {rem_reg, acc_reg[63]};
    assign div_ge   = div_sh >= {1'b0, dvs_reg};
    assign div_sub  = div_sh - {1'b0, dvs_reg};

    // Floor of a signed product over 2^16, kept as a magnitude: a negative
    // product rounds its magnitude up.
    assign rnd_sum  = {1'b0, acc_reg} + (sgn_reg ? FLOOR_ROUND : 65'd0);
    assign mag_q    = rnd_sum[64:16];

    // Integral update with saturation to the 32-bit range, then the
    // optional clamp.
    assign di_signed = di_sgn_reg ? -$signed({2'b00, di_mag_reg})
                                  : $signed({2'b00, di_mag_reg});
    assign i_sum     = 55'(integ_reg) + di_signed;

    always_comb
    begin
        if (i_sum > 55'sh0_7FFF_FFFF)
            i_sat = 32'sh7FFF_FFFF;
        else if (i_sum < -55'sh0_8000_0000)
            i_sat = 32'sh8000_0000;
        else
            i_sat = i_sum[31:0];

        if (clamp_en_reg && (i_sat > int_high_reg))
            i_new = int_high_reg;
        else if (clamp_en_reg && (i_sat < int_low_reg))
            i_new = int_low_reg;
        else
            i_new = i_sat;
    end

    assign p_signed = p_sgn_reg ? -$signed({14'd0, p_mag_reg})
                                : $signed({14'd0, p_mag_reg});
    assign d_signed = d_sgn_reg ? -$signed({4'd0, d_mag_reg})
                                : $signed({4'd0, d_mag_reg});

    always_comb
    begin
        if (u_reg > 62'(out_high_reg))
            u_clamped = out_high_reg;
        else if (u_reg < 62'(out_low_reg))
            u_clamped = out_low_reg;
        else
            u_clamped = u_reg[31:0];
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && !s_axis_tuser)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == 6'd0)
                    state_next = ST_NEXT;
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'd0)
                    state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                case (phase_reg)
                    PH_K:    state_next = ST_DIV;
                    PH_T:    state_next = ST_DIV;
                    PH_DI:   state_next = ST_INT;
                    default: state_next = ST_MUL;
                endcase
            end
            ST_INT:  state_next = ST_ADDP;
            ST_ADDP: state_next = ST_ADDD;
            ST_ADDD: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        out_free      = !out_valid_reg || m_axis_tready;
        out_load      = (state_reg == ST_DONE) && out_free;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Control state, configuration and kept controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            out_low_reg   <= '0;
            out_high_reg  <= '0;
            clamp_en_reg  <= 1'b0;
            int_low_reg   <= '0;
            int_high_reg  <= '0;
            prev_reg      <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_P:        gain_p_reg   <= cfg_data;
                    REG_GAIN_I:        gain_i_reg   <= cfg_data;
                    REG_GAIN_D:        gain_d_reg   <= cfg_data;
                    REG_OUT_LOW:       out_low_reg  <= cfg_data;
                    REG_OUT_HIGH:      out_high_reg <= cfg_data;
                    REG_CLAMP_ENABLE:  clamp_en_reg <= cfg_data[0];
                    REG_INTEGRAL_LOW:  int_low_reg  <= cfg_data;
                    REG_INTEGRAL_HIGH: int_high_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == ST_IDLE && s_fire && s_axis_tuser)
                integ_reg <= '0;
            else if (state_reg == ST_INT)
                integ_reg <= i_new;

            if (out_load)
                prev_reg <= e_reg;
        end
    end

    // Serial datapath. Each multiply shifts one multiplier bit per cycle;
    // each divide retires one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && !s_axis_tuser)
                begin
                    e_reg     <= in_e;
                    dt_reg    <= s_axis_tdata[47:32];
                    acc_reg   <= '0;
                    a_reg     <= {32'd0, gp_abs};
                    b_reg     <= {1'b0, in_e_abs};
                    sgn_reg   <= gain_p_reg[31] ^ in_e[31];
                    cnt_reg   <= CNT_MUL32;
                    phase_reg <= PH_P;
                end
            end
            ST_MUL:
            begin
                acc_reg <= mul_add;
                a_reg   <= {a_reg[62:0], 1'b0};
                b_reg   <= {1'b0, b_reg[32:1]};
                cnt_reg <= cnt_reg - 6'd1;
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? div_sub[15:0] : div_sh[15:0];
                acc_reg <= {acc_reg[62:0], div_ge};
                cnt_reg <= cnt_reg - 6'd1;
            end
            ST_NEXT:
            begin
                case (phase_reg)
                    PH_P:
                    begin
                        p_mag_reg <= mag_q[47:0];
                        p_sgn_reg <= sgn_reg;
                        acc_reg   <= '0;
                        if (dt_reg == 16'd0)
                        begin
                            // No elapsed time: the derivative is zero.
                            d_mag_reg <= '0;
                            d_sgn_reg <= 1'b0;
                            a_reg     <= {32'd0, gi_abs};
                            b_reg     <= {1'b0, e_abs};
                            sgn_reg   <= gain_i_reg[31] ^ e_reg[31];
                            cnt_reg   <= CNT_MUL32;
                            phase_reg <= PH_I;
                        end
                        else
                        begin
                            a_reg     <= {32'd0, gd_abs};
                            b_reg     <= diff_abs;
                            sgn_reg   <= gain_d_reg[31] ^ diff[32];
                            cnt_reg   <= CNT_MUL33;
                            phase_reg <= PH_D;
                        end
                    end
                    PH_D:
                    begin
                        acc_reg   <= '0;
                        a_reg     <= {15'd0, mag_q};
                        b_reg     <= {17'd0, MS_PER_SECOND};
                        cnt_reg   <= CNT_MUL10;
                        phase_reg <= PH_K;
                    end
                    PH_K:
                    begin
                        rem_reg   <= '0;
                        dvs_reg   <= dt_reg;
                        cnt_reg   <= CNT_DIV64;
                        phase_reg <= PH_DD;
                    end
                    PH_DD:
                    begin
                        d_mag_reg <= acc_reg[57:0];
                        d_sgn_reg <= sgn_reg;
                        acc_reg   <= '0;
                        a_reg     <= {32'd0, gi_abs};
                        b_reg     <= {1'b0, e_abs};
                        sgn_reg   <= gain_i_reg[31] ^ e_reg[31];
                        cnt_reg   <= CNT_MUL32;
                        phase_reg <= PH_I;
                    end
                    PH_I:
                    begin
                        acc_reg   <= '0;
                        a_reg     <= {15'd0, mag_q};
                        b_reg     <= {17'd0, dt_reg};
                        cnt_reg   <= CNT_MUL16;
                        phase_reg <= PH_T;
                    end
                    PH_T:
                    begin
                        rem_reg   <= '0;
                        dvs_reg   <= MS_PER_SECOND;
                        cnt_reg   <= CNT_DIV64;
                        phase_reg <= PH_DI;
                    end
                    PH_DI:
                    begin
                        di_mag_reg <= acc_reg[52:0];
                        di_sgn_reg <= sgn_reg;
                    end
                    default: ;
                endcase
            end
            ST_INT:  u_reg <= 62'(i_new);
            ST_ADDP: u_reg <= u_reg + p_signed;
            ST_ADDD: u_reg <= u_reg + d_signed;
            ST_DONE:
            begin
                if (out_load)
                    out_data_reg <= u_clamped;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    // The sequencer leaves idle only on an accepted compute beat.
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !(s_fire && !s_axis_tuser)) |=> state_reg == ST_IDLE)
        else $error("sequencer left idle without a compute beat");

    // A clear beat zeroes the integral.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && s_fire && s_axis_tuser) |=> integ_reg == 32'sd0)
        else $error("integral not cleared");

    // With clamping on and sane limits, the stored integral respects them.
    a_int_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INT && clamp_en_reg && int_low_reg <= int_high_reg)
        |=> (integ_reg >= $past(int_low_reg) && integ_reg <= $past(int_high_reg)))
        else $error("integral outside clamp limits");

    // A loaded result lies within sane output limits.
    a_out_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_low_reg <= out_high_reg)
        |=> ($signed(out_data_reg) >= $past(out_low_reg)
             && $signed(out_data_reg) <= $past(out_high_reg)))
        else $error("result outside output limits");

    // Zero elapsed time leaves the derivative at zero.
    a_dt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INT && dt_reg == 16'd0) |-> d_mag_reg == 58'd0)
        else $error("derivative nonzero with zero elapsed time");
`endif

endmodule

`default_nettype wire

/* sim/pid_controller_clamped_core_test.sv */
// Testbench for the clamped PID controller core: drives compute and clear
// beats, predicts every control output and checks it beat by beat.
// Depends on pidc_pkg and pid_controller_clamped_core.
`default_nettype none

module pid_controller_clamped_core_test;
    import pidc_pkg::*;

    localparam logic OP_COMPUTE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;
    localparam int   STALL_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // [31:0] error_in, [47:32] elapsed_ms
    logic        s_axis_tuser = 1'b0; // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] control_out
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    pid_controller_clamped_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Controller settings and state as the predictor sees them.
    logic signed [63:0] kp, ki, kd, out_lo, out_hi, int_lo, int_hi;
    logic               int_clamp_on;
    logic signed [63:0] prev_err, integ;

    logic [31:0] expected_drive[$];
    bit          failed = 0;
    bit          calm = 0;     // no idling in the closing part
    int          quiet_cycles = 0;

    function automatic logic signed [63:0] floor_frac(input logic signed [63:0] x);
        return x >>> FRAC_BITS;  // arithmetic shift rounds toward minus infinity
    endfunction

    function automatic logic signed [63:0] bound(input logic signed [63:0] v,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Works out one PID step and updates the predictor state.
    function automatic void predict_drive(input logic op, input logic [31:0] err_bits,
                                          input logic [15:0] dt_ms);
        logic signed [63:0] e, dt, p, d, i;
        e = {{32{err_bits[31]}}, err_bits};
        dt = {48'd0, dt_ms};
        if (op == OP_CLEAR) begin
            integ = 0;
            return;
        end
        p = floor_frac(kp * e);
        d = (dt == 0) ? 64'sd0 : floor_frac(kd * (e - prev_err)) * 1000 / dt;
        i = integ + floor_frac(ki * e) * dt / 1000;
        i = bound(i, -64'sd2147483648, 64'sd2147483647);
        if (int_clamp_on) i = bound(i, int_lo, int_hi);
        prev_err = e;
        integ = i;
        expected_drive.push_back(32'(bound(p + i + d, out_lo, out_hi)));
    endfunction

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic signed [63:0] s;
        s = {{32{val[31]}}, val};
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_GAIN_P:        kp = s;
            REG_GAIN_I:        ki = s;
            REG_GAIN_D:        kd = s;
            REG_OUT_LOW:       out_lo = s;
            REG_OUT_HIGH:      out_hi = s;
            REG_CLAMP_ENABLE:  int_clamp_on = val[0];
            REG_INTEGRAL_LOW:  int_lo = s;
            REG_INTEGRAL_HIGH: int_hi = s;
            default: ;
        endcase
    endtask

    // Waits until the block has drained, then a margin for a trailing clear.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_drive.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Leaves tvalid high after the accepting edge; the next beat or settle
    // drops it, so back-to-back beats keep it asserted.
    task automatic send_beat(input logic op, input logic [31:0] err,
                             input logic [15:0] dt);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {dt, err};
        do @(posedge clk); while (!s_axis_tready);
        predict_drive(op, err, dt);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_dt();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 50));
            default: return 16'($urandom);
        endcase
    endfunction

    // Result side: random stalls, and every beat compared with the oldest prediction.
    always @(posedge clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_drive.size() == 0) begin
                $display("%0t: unexpected control_out %h", $time, m_axis_tdata);
                failed = 1;
            end else begin
                if (m_axis_tdata !== expected_drive[0]) begin
                    $display("%0t: control_out expected %h actual %h",
                             $time, expected_drive[0], m_axis_tdata);
                    failed = 1;
                end
                void'(expected_drive.pop_front());
            end
        end
    end

    initial begin
        int gap;
        gap = 0;
        forever begin
            @(posedge clk);
            if (gap > 0) begin
                gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
            end
        end
    end

    // Watchdog: ends the run when nothing is accepted for too long.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic program_all(input logic [31:0] p, input logic [31:0] i,
                               input logic [31:0] d, input logic [31:0] olo,
                               input logic [31:0] ohi, input logic en,
                               input logic [31:0] ilo, input logic [31:0] ihi);
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_OUT_LOW, olo);
        write_reg(REG_OUT_HIGH, ohi);
        write_reg(REG_CLAMP_ENABLE, {31'd0, en});
        write_reg(REG_INTEGRAL_LOW, ilo);
        write_reg(REG_INTEGRAL_HIGH, ihi);
        cfg_we <= 1'b0;
    endtask

    // Extremes of error and elapsed time, zero elapsed time, clears, and
    // crossed limits where the low limit lies above the high one.
    task automatic test_directed();
        program_all(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h8000_0000,
                    32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0);
        send_beat(OP_COMPUTE, 32'h0001_0000, 16'd10);
        send_beat(OP_COMPUTE, 32'h7FFF_FFFF, 16'hFFFF);
        send_beat(OP_COMPUTE, 32'h8000_0000, 16'd0);
        send_beat(OP_COMPUTE, 32'h7FFF_FFFF, 16'd1);
        send_beat(OP_CLEAR,   32'hFFFF_FFFF, 16'hFFFF);
        send_beat(OP_COMPUTE, 32'hFFFF_0000, 16'd1000);
        send_beat(OP_COMPUTE, 32'h0000_0000, 16'd0);
        settle();
        // Full-scale gains drive the integral into 32-bit saturation both ways.
        program_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFF0_0000,
                    32'h0010_0000, 1'b0, 32'h0, 32'h0);
        repeat (3) send_beat(OP_COMPUTE, 32'h7FFF_FFFF, 16'hFFFF);
        repeat (3) send_beat(OP_COMPUTE, 32'h8000_0000, 16'hFFFF);
        settle();
        // Integral clamp on, then crossed integral and output limits.
        program_all(32'h0000_4000, 32'h0010_0000, 32'h0, 32'h8000_0000,
                    32'h7FFF_FFFF, 1'b1, 32'hFFFE_0000, 32'h0002_0000);
        repeat (2) send_beat(OP_COMPUTE, 32'h0005_0000, 16'd500);
        send_beat(OP_COMPUTE, 32'hFFF0_0000, 16'd700);
        settle();
        program_all(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000,
                    32'hFFFD_0000, 1'b1, 32'h0004_0000, 32'hFFFC_0000);
        send_beat(OP_COMPUTE, 32'h0002_0000, 16'd100);
        send_beat(OP_COMPUTE, 32'hFFF0_0000, 16'd100);
        send_beat(OP_COMPUTE, 32'h0010_0000, 16'd0);
        settle();
    endtask

    // Random phases, each with fresh settings; the last phase runs without idling.
    task automatic test_random();
        for (int phase = 0; phase < 8; phase++) begin
            logic [31:0] a, b;
            a = rand_word(); b = rand_word();
            program_all(rand_word(), rand_word(), rand_word(),
                        ($signed(a) < $signed(b)) ? a : b,
                        ($signed(a) < $signed(b)) ? b : a,
                        1'($urandom), rand_word(), rand_word());
            if (phase == 7) calm = 1;
            for (int n = 0; n < 200; n++)
                send_beat(($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_COMPUTE,
                          rand_word(), rand_dt());
            settle();
        end
    endtask

    initial begin
        {kp, ki, kd, out_lo, out_hi, int_lo, int_hi, prev_err, integ} = '0;
        int_clamp_on = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        if (!failed && expected_drive.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
